/* rtl/core/morse_keyer_top_assert.svh */
// Assertion macros for the keyer top level.
`ifndef MORSE_KEYER_TOP_ASSERT_SVH
`define MORSE_KEYER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keyer assertion failed");

// Next-cycle implication, checked out of reset.
`define MK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keyer assertion failed");

`endif

/* rtl/core/mk_pkg.sv */
`default_nettype none
package mk_pkg;

    localparam int MUL_W  = 16;
    localparam int PROD_W = 2 * MUL_W;
    localparam int LEN_W  = 18;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_EDGE   = 2'd1;
    localparam logic [1:0] ACT_INJECT = 2'd2;

    localparam logic [3:0] K_A_DOWN   = 4'd0;
    localparam logic [3:0] K_TONE_ON  = 4'd4;
    localparam logic [3:0] K_TONE_OFF = 4'd5;
    localparam logic [3:0] K_DOT      = 4'd6;
    localparam logic [3:0] K_DASH     = 4'd7;
    localparam logic [3:0] K_SPACE    = 4'd8;

    localparam logic [2:0] REG_AUTO_MODE  = 3'd0;
    localparam logic [2:0] REG_KEYER_EN   = 3'd1;
    localparam logic [2:0] REG_SWAP       = 3'd2;
    localparam logic [2:0] REG_ADAPT_EN   = 3'd3;
    localparam logic [2:0] REG_MANUAL_DIT = 3'd4;
    localparam logic [2:0] REG_AUTO_DIT   = 3'd5;
    localparam logic [2:0] REG_DAH_RATIO  = 3'd6;
    localparam logic [2:0] REG_GAP_RATIO  = 3'd7;

    localparam logic [11:0]     DIT_DEFAULT   = 12'd100;
    localparam logic [10:0]     DAH_DEFAULT   = 11'd563;
    localparam logic [10:0]     GAP_DEFAULT   = 11'd128;
    localparam logic [10:0]     GAP_FLOOR     = 11'd26;
    localparam logic [MUL_W-1:0] RECIP5       = 16'd26215;
    localparam int              RECIP5_SHIFT  = 17;

    // floor(product / 256) kept to LEN_W bits, at least 1
    function automatic logic [LEN_W-1:0] q8_min1(input logic [PROD_W-1:0] p);
        logic [LEN_W-1:0] v;
        v = p[LEN_W+7:8];
        return (v == '0) ? LEN_W'(1) : v;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/morse_keyer_top.sv */
// Morse keyer: straight key and iambic paddles. Each input beat (tick, key edge or
// injected symbol, with the current time in ms) yields zero to three result beats,
// the final one flagged by tlast. One shared 16x16 multiplier derives the dit, dash,
// gap and space-threshold lengths in turn (S_M0 to S_M3); S_DIV and S_DIVW use it
// to divide by five when a manual dot adapts the dit estimate. S_OUT sends one beat
// per cycle while tready is high; the input is not ready until all results have
// been taken. Configuration writes are accepted every cycle and must only be made
// while idle; a write to the mode register clears the paddle and tone state.
`default_nettype none
module morse_keyer_top
    import mk_pkg::*;
#(
    parameter int GROUP_GAP_RATIO_Q8     = 768,
    parameter int AUTO_FALLBACK_RATIO_Q8 = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // which_key, key_pressed, time_ms[31:0]
    input  wire logic [1:0]  i_s_tuser,   // action
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // kind[3:0]
    output logic             o_m_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_EX, S_DIV, S_DIVW, S_OUT
    } t_state;

    t_state r_state;

    logic r_auto, r_en, r_swap, r_adapt;
    logic [11:0] r_auto_dit;
    logic [10:0] r_dah_r, r_gap_r;

    logic r_ka, r_dot, r_dash, r_tone, r_gap, r_cur, r_pref, r_sp;
    logic [31:0] r_dl, r_press, r_last_sym;
    logic [11:0] r_est;

    logic [1:0]  r_act;
    logic        r_key, r_prs;
    logic [31:0] r_now;

    logic [14:0]      r_adit;
    logic [LEN_W-1:0] r_dah_len, r_gap_len;
    logic [14:0]      r_x;
    logic [11:0]      r_dur;
    logic             r_need_div;

    logic [3:0] r_buf [3];
    logic [1:0] r_cnt, r_idx;

    logic [MUL_W-1:0]  m_a, m_b;
    logic [PROD_W-1:0] m_prod;
    logic [LEN_W-1:0]  m_q8;
    logic [14:0]       adit_c;
    logic [10:0]       dah_eff, gap_eff;

    mk_mul u_mul (.i_clk(i_clk), .i_a(m_a), .i_b(m_b), .o_prod(m_prod));

    assign m_q8    = q8_min1(m_prod);
    assign adit_c  = (r_auto_dit != '0) ? 15'(r_auto_dit) : m_q8[14:0];
    assign dah_eff = (r_dah_r != '0) ? r_dah_r : DAH_DEFAULT;
    assign gap_eff = (r_gap_r == '0) ? GAP_DEFAULT :
                     (r_gap_r < GAP_FLOOR) ? GAP_FLOOR : r_gap_r;

    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_M0: begin
                m_a = MUL_W'(r_est);
                m_b = MUL_W'(AUTO_FALLBACK_RATIO_Q8);
            end
            S_M1: begin
                m_a = MUL_W'(adit_c);
                m_b = MUL_W'(dah_eff);
            end
            S_M2: begin
                m_a = MUL_W'(r_adit);
                m_b = MUL_W'(gap_eff);
            end
            S_M3: begin
                m_a = r_auto ? MUL_W'(r_adit) : MUL_W'(r_est);
                m_b = MUL_W'(GROUP_GAP_RATIO_Q8);
            end
            S_DIV: begin
                m_a = MUL_W'(r_x);
                m_b = RECIP5;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // deadline not yet reached
    function automatic logic e_dl_late(input logic [31:0] now, input logic [31:0] dl);
        logic [31:0] d;
        d = now - dl;
        return d[31];
    endfunction

    // one item's keying step
    logic e_ka, e_dot, e_dash, e_tone, e_gap, e_cur, e_pref, e_sp;
    logic [31:0] e_dl, e_press, e_last;
    logic [3:0]  e_k [3];
    logic [1:0]  e_n;
    logic        e_div, e_tick, e_go, e_isdot, e_sdash;
    logic [31:0] e_dur;
    logic [14:0] e_x;

    always_comb begin
        e_ka = r_ka; e_dot = r_dot; e_dash = r_dash; e_tone = r_tone;
        e_gap = r_gap; e_cur = r_cur; e_pref = r_pref; e_sp = r_sp;
        e_dl = r_dl; e_press = r_press; e_last = r_last_sym;
        e_k[0] = '0; e_k[1] = '0; e_k[2] = '0;
        e_n = '0; e_div = 1'b0; e_tick = 1'b0; e_go = 1'b0;
        e_isdot = 1'b0; e_sdash = 1'b0;
        e_dur = r_now - r_press;
        e_x = 15'({r_est, 2'b00}) + 15'(e_dur[11:0]);

        if (r_act == ACT_TICK) begin
            e_tick = r_auto;
        end else if (r_act == ACT_EDGE) begin
            e_k[e_n] = K_A_DOWN + {2'b00, r_key, 1'b0} + {3'b000, ~r_prs};
            e_n = e_n + 2'd1;
            if (r_en) begin
                if (r_auto) begin
                    e_isdot = ~r_key ^ r_swap;
                    if (e_isdot) e_dot = r_prs;
                    else e_dash = r_prs;
                    if (r_prs) e_pref = ~e_isdot;
                    e_ka = e_dot | e_dash | e_tone;
                    e_tick = 1'b1;
                end else if (!r_key) begin
                    if (r_prs) begin
                        e_ka = 1'b1;
                        e_press = r_now;
                        e_k[e_n] = K_TONE_ON;
                        e_n = e_n + 2'd1;
                    end else begin
                        e_k[e_n] = K_TONE_OFF;
                        e_n = e_n + 2'd1;
                        if (r_ka) begin
                            e_ka = 1'b0;
                            e_last = r_now;
                            e_sp = 1'b1;
                            if (e_dur <= 32'(r_est)) begin
                                e_k[e_n] = K_DOT;
                                e_n = e_n + 2'd1;
                                e_div = r_adapt & (e_dur != '0);
                            end else begin
                                e_k[e_n] = K_DASH;
                                e_n = e_n + 2'd1;
                            end
                        end
                    end
                end
            end
        end else if (r_act == ACT_INJECT) begin
            e_k[e_n] = r_key ? K_DASH : K_DOT;
            e_n = e_n + 2'd1;
            e_last = r_now;
            e_sp = 1'b1;
        end

        if (e_tick) begin
            if (e_tone) begin
                if (!e_dl_late(r_now, e_dl)) begin
                    e_k[e_n] = K_TONE_OFF;
                    e_n = e_n + 2'd1;
                    e_tone = 1'b0;
                    e_k[e_n] = e_cur ? K_DASH : K_DOT;
                    e_n = e_n + 2'd1;
                    e_last = r_now;
                    e_sp = 1'b1;
                    if (e_dot && e_dash) e_pref = ~e_cur;
                    else if (e_dot) e_pref = 1'b0;
                    else if (e_dash) e_pref = 1'b1;
                    e_gap = 1'b1;
                    e_dl = r_now + 32'(r_gap_len);
                    e_ka = e_dot | e_dash | e_tone;
                end
            end else begin
                e_go = 1'b1;
                if (e_gap) begin
                    if (e_dl_late(r_now, e_dl)) e_go = 1'b0;
                    else e_gap = 1'b0;
                end
                if (e_go) begin
                    if (e_dot || e_dash) begin
                        e_sdash = (e_dot && e_dash) ? e_pref : ~e_dot;
                        e_cur = e_sdash;
                        e_tone = 1'b1;
                        e_gap = 1'b0;
                        e_dl = r_now + (e_sdash ? 32'(r_dah_len) : 32'(r_adit));
                        e_ka = 1'b1;
                        e_k[e_n] = K_TONE_ON;
                        e_n = e_n + 2'd1;
                    end else begin
                        e_ka = e_dot | e_dash | e_tone;
                    end
                end
            end
        end

        if (r_act == ACT_TICK && e_sp && !e_ka && ((r_now - e_last) > 32'(m_q8))) begin
            e_k[e_n] = K_SPACE;
            e_n = e_n + 2'd1;
            e_last = r_now;
            e_sp = 1'b0;
        end
    end

    logic [11:0] div_e;
    assign div_e = m_prod[RECIP5_SHIFT+11:RECIP5_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_auto <= 1'b0; r_en <= 1'b1; r_swap <= 1'b0; r_adapt <= 1'b0;
            r_auto_dit <= '0;
            r_dah_r <= DAH_DEFAULT; r_gap_r <= GAP_DEFAULT;
            r_ka <= 1'b0; r_dot <= 1'b0; r_dash <= 1'b0; r_tone <= 1'b0;
            r_gap <= 1'b0; r_cur <= 1'b0; r_pref <= 1'b0; r_sp <= 1'b0;
            r_dl <= '0; r_press <= '0; r_last_sym <= '0;
            r_est <= DIT_DEFAULT;
            r_cnt <= '0; r_idx <= '0; r_need_div <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_AUTO_MODE: begin
                        r_auto <= i_cfg_data[0];
                        r_dot <= 1'b0; r_dash <= 1'b0; r_tone <= 1'b0;
                        r_gap <= 1'b0; r_cur <= 1'b0; r_pref <= 1'b0;
                        r_dl <= '0; r_ka <= 1'b0;
                    end
                    REG_KEYER_EN: r_en <= i_cfg_data[0];
                    REG_SWAP:     r_swap <= i_cfg_data[0];
                    REG_ADAPT_EN: r_adapt <= i_cfg_data[0];
                    REG_MANUAL_DIT: begin
                        r_est <= (i_cfg_data != '0) ? i_cfg_data : DIT_DEFAULT;
                    end
                    REG_AUTO_DIT:  r_auto_dit <= i_cfg_data;
                    REG_DAH_RATIO: r_dah_r <= i_cfg_data[10:0];
                    REG_GAP_RATIO: r_gap_r <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_act <= i_s_tuser;
                        r_key <= i_s_tdata[0];
                        r_prs <= i_s_tdata[1];
                        r_now <= i_s_tdata[33:2];
                        r_state <= S_M0;
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_adit <= adit_c;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_dah_len <= m_q8;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_gap_len <= m_q8;
                    r_state <= S_EX;
                end
                S_EX: begin
                    r_ka <= e_ka; r_dot <= e_dot; r_dash <= e_dash; r_tone <= e_tone;
                    r_gap <= e_gap; r_cur <= e_cur; r_pref <= e_pref; r_sp <= e_sp;
                    r_dl <= e_dl; r_press <= e_press; r_last_sym <= e_last;
                    r_buf[0] <= e_k[0]; r_buf[1] <= e_k[1]; r_buf[2] <= e_k[2];
                    r_cnt <= e_n;
                    r_idx <= '0;
                    r_x <= e_x;
                    r_dur <= e_dur[11:0];
                    r_need_div <= e_div;
                    if (e_div) r_state <= S_DIV;
                    else if (e_n == '0) r_state <= S_IDLE;
                    else r_state <= S_OUT;
                end
                S_DIV: r_state <= S_DIVW;
                S_DIVW: begin
                    r_est <= (div_e != '0) ? div_e : r_dur;
                    r_need_div <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        if (r_idx == r_cnt - 2'd1) r_state <= S_IDLE;
                        r_idx <= r_idx + 2'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE) && i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign o_m_tvalid  = (r_state == S_OUT);
    assign o_m_tdata   = {4'b0000, r_buf[r_idx]};
    assign o_m_tlast   = (r_idx == r_cnt - 2'd1);

`include "morse_keyer_top_assert.svh"

    `MK_ASSERT_NOW(a_sides_apart, o_s_tready, !o_m_tvalid)
    `MK_ASSERT_NOW(a_out_has_items, o_m_tvalid, r_cnt != '0)
    `MK_ASSERT_NEXT(a_last_ends_item, o_m_tvalid && i_m_tready && o_m_tlast, o_s_tready)
    `MK_ASSERT_NEXT(a_div_before_out, r_state == S_DIV, r_state == S_DIVW && r_need_div)

endmodule
`default_nettype wire

/* rtl/core/mk_mul.sv */
`default_nettype none
module mk_mul
    import mk_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [MUL_W-1:0]  i_a,
    input  wire logic [MUL_W-1:0]  i_b,
    output logic      [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire
